@@ design/bts_pkg.sv @@
// shared types, constants and conversion tables for the texture sampler
package bts_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = 12;
	localparam int SIZE_W      = 13;
	localparam int TC_W        = FRAC_BITS + 1;
	localparam int MUL_A_W     = 17;
	localparam int MUL_B_W     = 33;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W       = 49;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLER_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRGB_DECODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_PRESENT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DEF   = 3'd5;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [15:0] ONE_Q15  = 16'd32768;
	localparam logic [15:0] HALF_Q15 = 16'd16384;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MU   = 7'b0000010,
		ST_MV   = 7'b0000100,
		ST_AD   = 7'b0001000,
		ST_WT   = 7'b0010000,
		ST_MC   = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_op_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       wdata;
	} store_req_t;

	typedef logic [15:0] lut_t [0:255];

	function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	function automatic lut_t build_lin_lut();
		lut_t t;
		for (int c = 0; c < 256; c++) begin
			t[c] = 16'((64'(c) * 64'd65536 + 64'd255) / 64'd510);
		end
		return t;
	endfunction

	function automatic lut_t build_srgb_lut();
		lut_t t;
		logic [63:0] y, y2, lo, hi, mid, p, r;
		for (int c = 0; c < 256; c++) begin
			if (c <= 10) begin
				t[c] = 16'((64'(c) * 64'd6553600 + 64'd329460) / 64'd658920);
			end else begin
				y  = (((64'(c) * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
				y2 = mul_q30(y, y);
				lo = 64'd0;
				hi = 64'd1 << 30;
				for (int i = 0; i < 32; i++) begin
					if (lo < hi) begin
						mid = (lo + hi + 64'd1) >> 1;
						p = mul_q30(mid, mid);
						p = mul_q30(p, mid);
						p = mul_q30(p, mid);
						p = mul_q30(p, mid);
						if (p <= y2) lo = mid;
						else hi = mid - 64'd1;
					end
				end
				r = mul_q30(y2, lo);
				t[c] = 16'((r + (64'd1 << 14)) >> 15);
			end
		end
		return t;
	endfunction

	localparam lut_t LIN_LUT  = build_lin_lut();
	localparam lut_t SRGB_LUT = build_srgb_lut();

endpackage

@@ design/bts_mul.sv @@
// shared unsigned multiplier used by every working state of the sequencer (ST_MU through ST_MC)
module bts_mul (
	input  bts_pkg::mul_op_t                op,
	output logic [bts_pkg::MUL_P_W-1:0]     prod
);
	assign prod = bts_pkg::MUL_P_W'(op.a) * bts_pkg::MUL_P_W'(op.b);
endmodule

@@ design/bts_store.sv @@
// single-port texel store with registered read data
module bts_store (
	input  logic                 clk,
	input  bts_pkg::store_req_t  req,
	output logic [31:0]          rdata
);
	logic [31:0] mem [bts_pkg::STORE_DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	assign rdata = rdata_q;
endmodule

@@ design/bilinear_texture_sampler_unit.sv @@
// top level: config registers, sample sequencer, accumulators and result register
// one request at a time; stall stays high while a request is in work or a result waits
// a load is written into the store at accept; for a missing texture the result is registered at accept
// nearest reads one texel, bilinear four: setup in ST_MU and ST_MV, then per texel ST_AD, ST_WT and ST_MC per channel
// the sequence is set by the one shared multiplier and one store read per texel
// arst_n clears control and config to their reset values; store contents are undefined
module bilinear_texture_sampler_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bts_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic [11:0]                        texel_index,
	input  logic [31:0]                        texel_rgba,
	input  logic signed [23:0]                 u_coord,
	input  logic signed [23:0]                 v_coord,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [15:0]                        red,
	output logic [15:0]                        green,
	output logic [15:0]                        blue,
	output logic [15:0]                        alpha
);
	localparam int SW  = bts_pkg::SIZE_W;
	localparam int TW  = bts_pkg::TC_W;
	localparam int AW  = bts_pkg::ADDR_W;
	localparam logic [TW-1:0] S_ONE  = TW'(1) << bts_pkg::FRAC_BITS;
	localparam logic [29:0]   S_HALF = 30'(1) << (bts_pkg::FRAC_BITS - 1);

	logic [SW-1:0] tex_width_q, tex_height_q;
	logic [1:0]    sampler_mode_q;
	logic          srgb_decode_q, texture_present_q, normal_default_q;

	bts_pkg::state_t state_q;
	logic [1:0]      tex_q, ch_q;
	logic [TW-1:0]   tu_q, tv_q;
	logic [29:0]     qx_q, qy_q;
	logic [AW-1:0]   addr_q;
	logic [32:0]     wgt_q;
	logic [bts_pkg::ACC_W-1:0] acc_q [4];
	logic [15:0]     red_q, green_q, blue_q, alpha_q;
	logic            out_valid_q;

	logic accept, nearest, clamp;
	logic [SW-1:0] w_eff, h_eff;
	logic [TW-1:0] tu_d, tv_d;
	bts_pkg::mul_op_t mop;
	logic [bts_pkg::MUL_P_W-1:0] prod;
	bts_pkg::store_req_t sreq;
	logic [31:0] rdata;
	logic signed [14:0] x0, x1, y0, y1;
	logic [SW-1:0] xa0, xa1, ya0, ya1, xsel, ysel;
	logic [15:0] fx, fy;
	logic [TW-1:0] wx, wy;
	logic [7:0]  cbyte;
	logic [15:0] chan;

	function automatic logic [TW-1:0] norm(logic signed [23:0] c, logic clp);
		if (clp) begin
			if (c < 0) return '0;
			if (c > 24'sd65536) return S_ONE;
			return c[TW-1:0];
		end
		return {1'b0, c[bts_pkg::FRAC_BITS-1:0]};
	endfunction

	// texel coordinate comes in at most one past either edge
	function automatic logic [SW-1:0] axis(logic signed [14:0] x, logic [SW-1:0] n, logic clp);
		if (x < 0) return clp ? '0 : n - 1'b1;
		if (x >= $signed({2'b00, n})) return clp ? n - 1'b1 : '0;
		return x[SW-1:0];
	endfunction

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != bts_pkg::ST_IDLE) || out_valid_q;
	assign nearest   = sampler_mode_q[0];
	assign clamp     = sampler_mode_q[1];
	assign w_eff     = (tex_width_q == '0) ? SW'(1) : tex_width_q;
	assign h_eff     = (tex_height_q == '0) ? SW'(1) : tex_height_q;
	assign tu_d      = norm(u_coord, clamp);
	assign tv_d      = norm(v_coord, clamp);

	assign x0  = $signed({1'b0, qx_q[29:16]}) - (nearest ? 15'sd0 : 15'sd1);
	assign y0  = $signed({1'b0, qy_q[29:16]}) - (nearest ? 15'sd0 : 15'sd1);
	assign x1  = x0 + 15'sd1;
	assign y1  = y0 + 15'sd1;
	assign xa0 = axis(x0, w_eff, clamp);
	assign xa1 = axis(x1, w_eff, clamp);
	assign ya0 = axis(y0, h_eff, clamp);
	assign ya1 = axis(y1, h_eff, clamp);
	assign xsel = tex_q[0] ? xa1 : xa0;
	assign ysel = tex_q[1] ? ya1 : ya0;
	assign fx   = nearest ? 16'd0 : qx_q[15:0];
	assign fy   = nearest ? 16'd0 : qy_q[15:0];
	assign wx   = tex_q[0] ? {1'b0, fx} : S_ONE - {1'b0, fx};
	assign wy   = tex_q[1] ? {1'b0, fy} : S_ONE - {1'b0, fy};

	always_comb begin
		unique case (ch_q)
			2'd0: cbyte = rdata[7:0];
			2'd1: cbyte = rdata[15:8];
			2'd2: cbyte = rdata[23:16];
			default: cbyte = rdata[31:24];
		endcase
		chan = (srgb_decode_q && ch_q != 2'd3) ? bts_pkg::SRGB_LUT[cbyte]
		                                       : bts_pkg::LIN_LUT[cbyte];
	end

	always_comb begin
		mop = '0;
		unique case (state_q)
			bts_pkg::ST_MU: begin
				mop.a = tu_q;
				mop.b = 33'(w_eff);
			end
			bts_pkg::ST_MV: begin
				mop.a = tv_q;
				mop.b = 33'(h_eff);
			end
			bts_pkg::ST_AD: begin
				mop.a = 17'(ysel);
				mop.b = 33'(w_eff);
			end
			bts_pkg::ST_WT: begin
				mop.a = wx;
				mop.b = 33'(wy);
			end
			bts_pkg::ST_MC: begin
				mop.a = 17'(chan);
				mop.b = wgt_q;
			end
			default: mop = '0;
		endcase
	end

	bts_mul u_mul (
		.op   (mop),
		.prod (prod)
	);

	always_comb begin
		sreq       = '0;
		sreq.wdata = texel_rgba;
		if (state_q == bts_pkg::ST_IDLE) begin
			sreq.en   = accept && kind == bts_pkg::KIND_LOAD;
			sreq.we   = 1'b1;
			sreq.addr = texel_index;
		end else begin
			sreq.en   = state_q == bts_pkg::ST_WT;
			sreq.addr = addr_q;
		end
	end

	bts_store u_store (
		.clk   (clk),
		.req   (sreq),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q       <= SW'(1);
			tex_height_q      <= SW'(1);
			sampler_mode_q    <= '0;
			srgb_decode_q     <= 1'b0;
			texture_present_q <= 1'b0;
			normal_default_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bts_pkg::REG_TEX_WIDTH:    tex_width_q       <= cfg_data;
				bts_pkg::REG_TEX_HEIGHT:   tex_height_q      <= cfg_data;
				bts_pkg::REG_SAMPLER_MODE: sampler_mode_q    <= cfg_data[1:0];
				bts_pkg::REG_SRGB_DECODE:  srgb_decode_q     <= cfg_data[0];
				bts_pkg::REG_TEX_PRESENT:  texture_present_q <= cfg_data[0];
				bts_pkg::REG_NORMAL_DEF:   normal_default_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bts_pkg::ST_IDLE;
			tex_q       <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				bts_pkg::ST_IDLE: begin
					if (accept && kind == bts_pkg::KIND_SAMPLE) begin
						if (texture_present_q) begin
							state_q <= bts_pkg::ST_MU;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
					tex_q <= '0;
					ch_q  <= '0;
				end
				bts_pkg::ST_MU: state_q <= bts_pkg::ST_MV;
				bts_pkg::ST_MV: state_q <= bts_pkg::ST_AD;
				bts_pkg::ST_AD: state_q <= bts_pkg::ST_WT;
				bts_pkg::ST_WT: state_q <= bts_pkg::ST_MC;
				bts_pkg::ST_MC: begin
					ch_q <= ch_q + 2'd1;
					if (ch_q == 2'd3) begin
						if (nearest || tex_q == 2'd3) begin
							state_q <= bts_pkg::ST_DONE;
						end else begin
							tex_q   <= tex_q + 2'd1;
							state_q <= bts_pkg::ST_AD;
						end
					end
				end
				bts_pkg::ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= bts_pkg::ST_IDLE;
				end
				default: state_q <= bts_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bts_pkg::ST_IDLE: begin
				tu_q <= tu_d;
				tv_q <= tv_d;
				for (int k = 0; k < 4; k++) acc_q[k] <= '0;
				if (accept && kind == bts_pkg::KIND_SAMPLE && !texture_present_q) begin
					red_q   <= normal_default_q ? bts_pkg::HALF_Q15 : bts_pkg::ONE_Q15;
					green_q <= normal_default_q ? bts_pkg::HALF_Q15 : bts_pkg::ONE_Q15;
					blue_q  <= bts_pkg::ONE_Q15;
					alpha_q <= bts_pkg::ONE_Q15;
				end
			end
			bts_pkg::ST_MU: qx_q <= prod[29:0] + (nearest ? 30'd0 : S_HALF);
			bts_pkg::ST_MV: qy_q <= prod[29:0] + (nearest ? 30'd0 : S_HALF);
			// address wraps modulo the store depth
			bts_pkg::ST_AD: addr_q <= prod[AW-1:0] + xsel[AW-1:0];
			bts_pkg::ST_WT: wgt_q <= prod[32:0];
			bts_pkg::ST_MC: acc_q[ch_q] <= acc_q[ch_q] + prod[bts_pkg::ACC_W-1:0];
			bts_pkg::ST_DONE: begin
				// round half up out of the 2F weight scale
				red_q   <= 16'((acc_q[0] + (49'd1 << 31)) >> 32);
				green_q <= 16'((acc_q[1] + (49'd1 << 31)) >> 32);
				blue_q  <= 16'((acc_q[2] + (49'd1 << 31)) >> 32);
				alpha_q <= 16'((acc_q[3] + (49'd1 << 31)) >> 32);
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign alpha     = alpha_q;

	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> in_stall)
		else $error("request taken while a result waits");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == bts_pkg::ST_DONE ||
			(accept && kind == bts_pkg::KIND_SAMPLE && !texture_present_q)))
		else $error("result without a finished sample");

	a_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bts_pkg::ST_MU) |-> (tex_q == 2'd0 && ch_q == 2'd0))
		else $error("sequencer counters not cleared at start");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (red_q <= bts_pkg::ONE_Q15 && green_q <= bts_pkg::ONE_Q15 &&
			blue_q <= bts_pkg::ONE_Q15 && alpha_q <= bts_pkg::ONE_Q15))
		else $error("channel above one");

endmodule

@@ tb/bts_checker.sv @@
// request and result monitor for the texture sampler: predicts and compares each result
`timescale 1ns / 100ps

module bts_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic [11:0]        texel_index,
	input  logic [31:0]        texel_rgba,
	input  logic signed [23:0] u_coord,
	input  logic signed [23:0] v_coord,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [15:0]        red,
	input  logic [15:0]        green,
	input  logic [15:0]        blue,
	input  logic [15:0]        alpha,
	output int                 fails,
	output int                 pending
);

	localparam int       NEAREST_BIT = 0;
	localparam int       CLAMP_BIT   = 1;
	localparam longint   UNIT        = 64'sd1 << bts_pkg::FRAC_BITS;

	typedef struct packed {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic [15:0] a;
	} colour_t;

	logic [31:0] texels [0:bts_pkg::STORE_DEPTH-1];
	logic [15:0] srgb_q15 [0:255];
	logic [12:0] width_reg, height_reg;
	logic [1:0]  mode_reg;
	logic        srgb_on, present_on, normal_on;
	colour_t     colours_due [$];

	function automatic longint unsigned round_q30(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	// largest fifth root of y squared in q0.30, then times y squared
	function automatic logic [15:0] srgb_entry(int c);
		longint unsigned y, ysq, lo, hi, mid, pw;
		if (c <= 10)
			return 16'((64'(c) * 64'd6553600 + 64'd329460) / 64'd658920);
		y = (((64'(c) * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
		ysq = round_q30(y, y);
		lo = 0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			pw = round_q30(round_q30(round_q30(round_q30(mid, mid), mid), mid), mid);
			if (pw <= ysq) lo = mid;
			else hi = mid - 1;
		end
		return 16'((round_q30(ysq, lo) + (64'd1 << 14)) >> 15);
	endfunction

	initial begin
		for (int c = 0; c < 256; c++) srgb_q15[c] = srgb_entry(c);
	end

	function automatic longint unsigned chan_q15(logic [31:0] t, int k);
		logic [7:0] c;
		c = t[8*k +: 8];
		if (k < 3 && srgb_on) return srgb_q15[c];
		return (64'(c) * 64'd65536 + 64'd255) / 64'd510;
	endfunction

	function automatic longint norm_coord(logic signed [23:0] c, bit clamp);
		longint cv;
		cv = c;
		if (!clamp) return cv & (UNIT - 1);
		if (cv < 0) return 0;
		if (cv > UNIT) return UNIT;
		return cv;
	endfunction

	function automatic longint edge_axis(longint p, longint n, bit clamp);
		if (clamp) return (p < 0) ? 0 : ((p > n - 1) ? n - 1 : p);
		return ((p % n) + n) % n;
	endfunction

	function automatic logic [31:0] texel_at(longint x, longint y, longint w, longint h,
			bit clamp);
		longint addr;
		addr = edge_axis(y, h, clamp) * w + edge_axis(x, w, clamp);
		return texels[addr % bts_pkg::STORE_DEPTH];
	endfunction

	function automatic colour_t filtered_colour(logic signed [23:0] u, logic signed [23:0] v);
		colour_t res;
		longint w, h, tu, tv, qx, qy, x0, y0, fx, fy;
		longint unsigned wt [4];
		logic [31:0] t [4];
		longint unsigned acc [4];
		bit clamp;
		if (!present_on) begin
			res.r = normal_on ? bts_pkg::HALF_Q15 : bts_pkg::ONE_Q15;
			res.g = res.r;
			res.b = bts_pkg::ONE_Q15;
			res.a = bts_pkg::ONE_Q15;
			return res;
		end
		w = (width_reg == 0) ? 1 : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		clamp = mode_reg[CLAMP_BIT];
		tu = norm_coord(u, clamp);
		tv = norm_coord(v, clamp);
		if (mode_reg[NEAREST_BIT]) begin
			t[0] = texel_at((tu * w) >>> bts_pkg::FRAC_BITS, (tv * h) >>> bts_pkg::FRAC_BITS,
				w, h, clamp);
			for (int k = 0; k < 4; k++) acc[k] = chan_q15(t[0], k);
		end else begin
			qx = tu * w + UNIT / 2;
			qy = tv * h + UNIT / 2;
			x0 = (qx >>> bts_pkg::FRAC_BITS) - 1;
			y0 = (qy >>> bts_pkg::FRAC_BITS) - 1;
			fx = qx & (UNIT - 1);
			fy = qy & (UNIT - 1);
			wt[0] = (UNIT - fx) * (UNIT - fy);
			wt[1] = fx * (UNIT - fy);
			wt[2] = (UNIT - fx) * fy;
			wt[3] = fx * fy;
			t[0] = texel_at(x0, y0, w, h, clamp);
			t[1] = texel_at(x0 + 1, y0, w, h, clamp);
			t[2] = texel_at(x0, y0 + 1, w, h, clamp);
			t[3] = texel_at(x0 + 1, y0 + 1, w, h, clamp);
			for (int k = 0; k < 4; k++) begin
				acc[k] = 64'd1 << (2 * bts_pkg::FRAC_BITS - 1);
				for (int n = 0; n < 4; n++) acc[k] += chan_q15(t[n], k) * wt[n];
				acc[k] = acc[k] >> (2 * bts_pkg::FRAC_BITS);
			end
		end
		res.r = acc[0][15:0];
		res.g = acc[1][15:0];
		res.b = acc[2][15:0];
		res.a = acc[3][15:0];
		return res;
	endfunction

	assign pending = colours_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  <= 13'd1;
			height_reg <= 13'd1;
			mode_reg   <= 2'd0;
			srgb_on    <= 1'b0;
			present_on <= 1'b0;
			normal_on  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bts_pkg::REG_TEX_WIDTH:    width_reg  <= cfg_data;
				bts_pkg::REG_TEX_HEIGHT:   height_reg <= cfg_data;
				bts_pkg::REG_SAMPLER_MODE: mode_reg   <= cfg_data[1:0];
				bts_pkg::REG_SRGB_DECODE:  srgb_on    <= cfg_data[0];
				bts_pkg::REG_TEX_PRESENT:  present_on <= cfg_data[0];
				bts_pkg::REG_NORMAL_DEF:   normal_on  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		colour_t seen, due;
		if (arst_n && in_valid && !in_stall) begin
			if (kind == bts_pkg::KIND_LOAD) texels[texel_index] = texel_rgba;
			else colours_due.push_back(filtered_colour(u_coord, v_coord));
		end
		if (arst_n && out_valid && !out_stall) begin
			seen = {red, green, blue, alpha};
			if (colours_due.size() == 0) begin
				fails++;
				if (fails <= 10) $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
					red, green, blue, alpha);
			end else begin
				due = colours_due.pop_front();
				if (seen !== due) begin
					fails++;
					if (fails <= 10)
						$display({"mismatch: expected r=%0d g=%0d b=%0d a=%0d,",
							" got r=%0d g=%0d b=%0d a=%0d"},
							due.r, due.g, due.b, due.a, red, green, blue, alpha);
				end
			end
		end
	end

endmodule

@@ tb/tb_bilinear_texture_sampler_unit.sv @@
// top of the texture sampler testbench: clock, reset, request and stall generation, verdict
`timescale 1ns / 100ps

module tb_bilinear_texture_sampler_unit;

	localparam int         CYCLE_LIMIT  = 2000000;
	localparam int         SETTLE       = 40;
	localparam int         PRELOAD      = 256;
	localparam int         ROUNDS       = 14;
	localparam int         ROUND_ITEMS  = 20;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [12:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = bts_pkg::KIND_LOAD;
	logic [11:0]        texel_index = '0;
	logic [31:0]        texel_rgba = '0;
	logic signed [23:0] u_coord = '0;
	logic signed [23:0] v_coord = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        red, green, blue, alpha;
	int                 fails, pending;
	int                 cycles = 0;
	bit                 calm = 1'b0;
	int                 stall_left = 0;

	bilinear_texture_sampler_unit dut (.*);

	bts_checker chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("bilinear_texture_sampler_unit test failed");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (calm) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1) out_stall <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(1, 19);
		end
	end

	// called at a rising edge; returns at the edge where the request was taken
	task automatic send(logic k, logic [11:0] idx, logic [31:0] rgba,
			logic signed [23:0] u, logic signed [23:0] v);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		texel_index <= idx;
		texel_rgba  <= rgba;
		u_coord     <= u;
		v_coord     <= v;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	task automatic load_texel(logic [11:0] idx);
		send(bts_pkg::KIND_LOAD, idx, $urandom, '0, '0);
	endtask

	function automatic logic signed [23:0] any_coord();
		if ($urandom_range(0, 3) == 0) return 24'($urandom);
		return 24'($signed($urandom_range(0, 4 << bts_pkg::FRAC_BITS))
			- (2 << bts_pkg::FRAC_BITS));
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [12:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_texture(int w, int h, logic [1:0] mode, bit srgb, bit present,
			bit normal);
		set_reg(bts_pkg::REG_TEX_WIDTH, 13'(w));
		set_reg(bts_pkg::REG_TEX_HEIGHT, 13'(h));
		set_reg(bts_pkg::REG_SAMPLER_MODE, 13'(mode));
		set_reg(bts_pkg::REG_SRGB_DECODE, 13'(srgb));
		set_reg(bts_pkg::REG_TEX_PRESENT, 13'(present));
		set_reg(bts_pkg::REG_NORMAL_DEF, 13'(normal));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic mixed_requests(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 3) load_texel(12'($urandom));
			else send(bts_pkg::KIND_SAMPLE, '0, '0, any_coord(), any_coord());
		end
	endtask

	int dir_w [10] = '{1, 4096, 1, 0, 16, 3, 4096, 17, 2, 8};
	int dir_h [10] = '{1, 1, 4096, 0, 16, 5, 4096, 9, 2, 8};
	// each of these lands on the first or last texel of a full-size row or column
	logic signed [23:0] edge_coords [8] = '{24'sd0, 24'sd65535, 24'sd65536, -24'sd1,
		24'sh800000, 24'sd8388607, 24'sd131072, -24'sd65536};

	initial begin
		int w, h;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// missing texture with default still in place, before any texel is held
		send(bts_pkg::KIND_SAMPLE, '0, '0, 24'sd0, 24'sd0);
		settle();
		set_texture(1, 1, 2'd0, 1'b0, 1'b0, 1'b1);
		send(bts_pkg::KIND_SAMPLE, '0, '0, -24'sd1, 24'sd8388607);
		settle();

		// fill the low store entries and the last one; every texture below reads only these
		send(bts_pkg::KIND_LOAD, 12'd0, 32'h0000_0000, '0, '0);
		send(bts_pkg::KIND_LOAD, 12'd4095, 32'hFFFF_FFFF, '0, '0);
		for (int i = 1; i < PRELOAD; i++) load_texel(12'(i));
		settle();

		for (int p = 0; p < 10; p++) begin
			set_texture(dir_w[p], dir_h[p], 2'(p), p[2], 1'b1, 1'b0);
			for (int i = 0; i < 8; i++)
				send(bts_pkg::KIND_SAMPLE, '0, '0, edge_coords[i], edge_coords[(i + 3) % 8]);
			if (dir_w[p] * dir_h[p] <= PRELOAD) mixed_requests(3);
			settle();
		end

		for (int p = 0; p < ROUNDS; p++) begin
			calm = (p >= ROUNDS - 3);
			w = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 16));
			h = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 16));
			set_texture(w, h, 2'($urandom_range(0, 3)), 1'($urandom),
				$urandom_range(0, 5) != 0, 1'($urandom));
			mixed_requests(ROUND_ITEMS);
			settle();
		end

		if (fails == 0 && pending == 0)
			$display("bilinear_texture_sampler_unit test passed");
		else
			$display("bilinear_texture_sampler_unit test failed");
		$finish;
	end

endmodule

@@ files.f @@
design/bts_pkg.sv
design/bts_mul.sv
design/bts_store.sv
design/bilinear_texture_sampler_unit.sv
tb/bts_checker.sv
tb/tb_bilinear_texture_sampler_unit.sv
